// ----- design/aarm_pkg.sv -----
package aarm_pkg;

  // field widths
  localparam int AxW  = 16;                 // axis and angle, Q1.14 / Q3.13
  localparam int OutW = 16;                 // matrix entries, Q1.14
  localparam int CordW = 20;                // CORDIC x, y, z in Q.16
  localparam int ScW  = 17;                 // sin and (1 - cos) in Q2.14
  localparam int PrW  = 2 * AxW;            // axis products, Q2.28
  localparam int KkW  = PrW + 1;            // K*K diagonal needs one more bit
  localparam int AccW = 50;                 // Q.42 entry sum

  // CORDIC pipeline shape
  localparam int CordicSteps   = 16;
  localparam int StepsPerStage = 2;
  localparam int CordicStages  = CordicSteps / StepsPerStage;
  localparam int StepIdxW      = $clog2(CordicSteps);
  // fold register + iteration stages + sin/cos register
  localparam int CordicLat     = CordicStages + 2;
  // axis side: product register and K*K register come first
  localparam int AxisDelay     = CordicLat - 2;
  localparam int MatLat        = 3;

  localparam logic signed [CordW-1:0] QPi     = 20'sd205887;
  localparam logic signed [CordW-1:0] QHalfPi = 20'sd102944;
  localparam logic signed [CordW-1:0] CordGain = 20'sd39797;
  localparam logic signed [ScW-1:0]   QOne14  = 17'sd16384;

  localparam logic signed [CordW-1:0] AtanTab [CordicSteps] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2
  };

  typedef struct packed {
    logic signed [AxW-1:0] axis_x;
    logic signed [AxW-1:0] axis_y;
    logic signed [AxW-1:0] axis_z;
    logic signed [AxW-1:0] angle;
  } in_word_t;

  typedef struct packed {
    logic signed [OutW-1:0] r_row0_col0;
    logic signed [OutW-1:0] r_row0_col1;
    logic signed [OutW-1:0] r_row0_col2;
    logic signed [OutW-1:0] r_row1_col0;
    logic signed [OutW-1:0] r_row1_col1;
    logic signed [OutW-1:0] r_row1_col2;
    logic signed [OutW-1:0] r_row2_col0;
    logic signed [OutW-1:0] r_row2_col1;
    logic signed [OutW-1:0] r_row2_col2;
  } out_word_t;

  typedef struct packed {
    logic signed [AxW-1:0] x;
    logic signed [AxW-1:0] y;
    logic signed [AxW-1:0] z;
  } axis_t;

  // unique K*K entries (matrix is symmetric)
  typedef struct packed {
    logic signed [KkW-1:0] d0;
    logic signed [KkW-1:0] d1;
    logic signed [KkW-1:0] d2;
    logic signed [KkW-1:0] o01;
    logic signed [KkW-1:0] o02;
    logic signed [KkW-1:0] o12;
  } kk_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
  } cordic_t;

  function automatic cordic_t cordic_step(cordic_t a, logic [StepIdxW-1:0] idx);
    cordic_t b;
    logic signed [CordW-1:0] dx;
    logic signed [CordW-1:0] dy;
    dx = $signed(a.y) >>> idx;
    dy = $signed(a.x) >>> idx;
    if (!a.z[CordW-1]) begin
      b.x = a.x - dx;
      b.y = a.y + dy;
      b.z = a.z - AtanTab[idx];
    end else begin
      b.x = a.x + dx;
      b.y = a.y - dy;
      b.z = a.z + AtanTab[idx];
    end
    return b;
  endfunction

  // StepsPerStage dependent iterations starting at step 'base'
  function automatic cordic_t cordic_span(cordic_t a, int base);
    cordic_t b;
    b = a;
    for (int k = 0; k < StepsPerStage; k++) begin
      b = cordic_step(b, StepIdxW'(base + k));
    end
    return b;
  endfunction

endpackage

// ----- design/aarm_cordic.sv -----
module aarm_cordic import aarm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic signed [AxW-1:0] in_angle,
  output logic                  out_vld,
  output logic signed [ScW-1:0] sin_q,
  output logic signed [ScW-1:0] omc_q
);

  logic                    vld_r  [CordicLat];
  cordic_t                 st_r   [CordicStages+1];
  cordic_t                 st_nxt [1:CordicStages];
  cordic_t                 fold_nxt;
  logic                    flip_r [CordicStages+1];
  logic                    flip_nxt;
  logic signed [ScW-1:0]   sin_r, sin_nxt;
  logic signed [ScW-1:0]   omc_r, omc_nxt;

  // quadrant fold into [-pi/2, pi/2]
  logic signed [CordW-1:0] ang_q16;
  assign ang_q16 = {{(CordW-AxW-3){in_angle[AxW-1]}}, in_angle, 3'b000};

  always_comb begin
    fold_nxt.x = CordGain;
    fold_nxt.y = '0;
    fold_nxt.z = ang_q16;
    flip_nxt   = 1'b0;
    if (ang_q16 > QHalfPi) begin
      fold_nxt.z = QPi - ang_q16;
      flip_nxt   = 1'b1;
    end else if (ang_q16 < -QHalfPi) begin
      fold_nxt.z = -QPi - ang_q16;
      flip_nxt   = 1'b1;
    end
  end

  for (genvar g = 1; g <= CordicStages; g++) begin : g_stage
    assign st_nxt[g] = cordic_span(st_r[g-1], (g - 1) * StepsPerStage);
  end

  // round to Q1.14; cos changes sign after a fold
  logic signed [CordW-1:0] ys, xs;
  logic signed [ScW-1:0]   cos_q;
  assign ys = st_r[CordicStages].y + CordW'(2);
  assign xs = st_r[CordicStages].x + CordW'(2);
  assign sin_nxt = ys[ScW+1:2];
  assign cos_q   = xs[ScW+1:2];
  assign omc_nxt = flip_r[CordicStages] ? (QOne14 + cos_q) : (QOne14 - cos_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CordicLat; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < CordicLat; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flip_r[0] <= flip_nxt;
      st_r[0]   <= fold_nxt;
      for (int i = 1; i <= CordicStages; i++) st_r[i] <= st_nxt[i];
      for (int i = 1; i <= CordicStages; i++) flip_r[i] <= flip_r[i-1];
      sin_r <= sin_nxt;
      omc_r <= omc_nxt;
    end
  end

  assign out_vld = vld_r[CordicLat-1];
  assign sin_q   = sin_r;
  assign omc_q   = omc_r;

endmodule

// ----- design/aarm_axis.sv -----
module aarm_axis import aarm_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  axis_t in_axis,
  output axis_t out_axis,
  output kk_t   out_kk
);

  axis_t                 ax_r [CordicLat];
  logic signed [PrW-1:0] pxx_r, pyy_r, pzz_r, pxy_r, pxz_r, pyz_r;
  kk_t                   kk_nxt;
  kk_t                   kk_r [AxisDelay+1];

  // K*K: diagonal is minus the sum of the other two squares
  always_comb begin
    kk_nxt.d0  = -(KkW'(pyy_r) + KkW'(pzz_r));
    kk_nxt.d1  = -(KkW'(pxx_r) + KkW'(pzz_r));
    kk_nxt.d2  = -(KkW'(pxx_r) + KkW'(pyy_r));
    kk_nxt.o01 = KkW'(pxy_r);
    kk_nxt.o02 = KkW'(pxz_r);
    kk_nxt.o12 = KkW'(pyz_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxx_r <= in_axis.x * in_axis.x;
      pyy_r <= in_axis.y * in_axis.y;
      pzz_r <= in_axis.z * in_axis.z;
      pxy_r <= in_axis.x * in_axis.y;
      pxz_r <= in_axis.x * in_axis.z;
      pyz_r <= in_axis.y * in_axis.z;
      kk_r[0] <= kk_nxt;
      for (int i = 1; i <= AxisDelay; i++) kk_r[i] <= kk_r[i-1];
      ax_r[0] <= in_axis;
      for (int i = 1; i < CordicLat; i++) ax_r[i] <= ax_r[i-1];
    end
  end

  assign out_axis = ax_r[CordicLat-1];
  assign out_kk   = kk_r[AxisDelay];

endmodule

// ----- design/aarm_mat.sv -----
module aarm_mat import aarm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic signed [ScW-1:0] sin_q,
  input  logic signed [ScW-1:0] omc_q,
  input  axis_t                 ax,
  input  kk_t                   kk,
  output logic                  out_vld,
  output out_word_t             out_word
);

  localparam int SpW = ScW + AxW;
  localparam int MpW = ScW + KkW;
  localparam int RsW = AccW - 28;
  localparam logic signed [AccW-1:0] IdentQ42 = AccW'(64'sh400_0000_0000);
  localparam logic signed [AccW-1:0] HalfQ28  = AccW'(64'sh800_0000);
  localparam logic signed [RsW-1:0]  SatHi    = RsW'(32767);
  localparam logic signed [RsW-1:0]  SatLo    = -RsW'(32768);

  logic                   vld_r [MatLat];
  logic signed [SpW-1:0]  sx_r, sy_r, sz_r;
  logic signed [MpW-1:0]  m0_r, m1_r, m2_r, m01_r, m02_r, m12_r;
  logic signed [AccW-1:0] v_r   [9];
  logic signed [AccW-1:0] v_nxt [9];
  logic signed [AccW-1:0] sx14, sy14, sz14;
  out_word_t              out_r, out_nxt;

  function automatic logic signed [OutW-1:0] round_sat(logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    logic signed [RsW-1:0]  r;
    t = v + HalfQ28;
    r = t[AccW-1:28];
    if (r > SatHi)      return OutW'(SatHi);
    else if (r < SatLo) return OutW'(SatLo);
    else                return r[OutW-1:0];
  endfunction

  assign sx14 = AccW'(sx_r) <<< 14;
  assign sy14 = AccW'(sy_r) <<< 14;
  assign sz14 = AccW'(sz_r) <<< 14;

  // R = I + s*K + (1 - cos)*K*K
  always_comb begin
    v_nxt[0] = IdentQ42 + AccW'(m0_r);
    v_nxt[1] = AccW'(m01_r) - sz14;
    v_nxt[2] = AccW'(m02_r) + sy14;
    v_nxt[3] = AccW'(m01_r) + sz14;
    v_nxt[4] = IdentQ42 + AccW'(m1_r);
    v_nxt[5] = AccW'(m12_r) - sx14;
    v_nxt[6] = AccW'(m02_r) - sy14;
    v_nxt[7] = AccW'(m12_r) + sx14;
    v_nxt[8] = IdentQ42 + AccW'(m2_r);
  end

  always_comb begin
    out_nxt.r_row0_col0 = round_sat(v_r[0]);
    out_nxt.r_row0_col1 = round_sat(v_r[1]);
    out_nxt.r_row0_col2 = round_sat(v_r[2]);
    out_nxt.r_row1_col0 = round_sat(v_r[3]);
    out_nxt.r_row1_col1 = round_sat(v_r[4]);
    out_nxt.r_row1_col2 = round_sat(v_r[5]);
    out_nxt.r_row2_col0 = round_sat(v_r[6]);
    out_nxt.r_row2_col1 = round_sat(v_r[7]);
    out_nxt.r_row2_col2 = round_sat(v_r[8]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MatLat; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < MatLat; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r  <= sin_q * ax.x;
      sy_r  <= sin_q * ax.y;
      sz_r  <= sin_q * ax.z;
      m0_r  <= omc_q * kk.d0;
      m1_r  <= omc_q * kk.d1;
      m2_r  <= omc_q * kk.d2;
      m01_r <= omc_q * kk.o01;
      m02_r <= omc_q * kk.o02;
      m12_r <= omc_q * kk.o12;
      for (int i = 0; i < 9; i++) v_r[i] <= v_nxt[i];
      out_r <= out_nxt;
    end
  end

  assign out_vld  = vld_r[MatLat-1];
  assign out_word = out_r;

endmodule

// ----- design/axis_angle_rotation_matrix_unit.sv -----
// Channel  Dir  Handshake            Word
// in_      in   in_valid/in_ready    in_word_t: axis_x, axis_y, axis_z (Q1.14), angle (Q3.13)
// out_     out  out_valid/out_ready  out_word_t: r_rowI_colJ, nine Q1.14 entries
//
// One word per cycle in and out while the output is not stalled.
// The pipe is the 16-step CORDIC (two steps per stage, 8 stages,
// plus fold and rounding registers) followed by multiply, sum and round stages.
// Reset (rst_n low, synchronous) clears only the valid bits; data regs keep junk.
// Stall: the whole pipe freezes while a result sits unread; in_ready is low
// exactly then, so nothing is dropped or repeated and bubbles pass through.
module axis_angle_rotation_matrix_unit import aarm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // global advance: output register empty or being drained
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic                  cord_vld;
  logic signed [ScW-1:0] sin_q, omc_q;
  axis_t                 ax_in, ax_dly;
  kk_t                   kk_dly;

  assign ax_in.x = in_data.axis_x;
  assign ax_in.y = in_data.axis_y;
  assign ax_in.z = in_data.axis_z;

  // sin / (1 - cos) path
  aarm_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_angle (in_data.angle),
    .out_vld  (cord_vld),
    .sin_q    (sin_q),
    .omc_q    (omc_q)
  );

  // K*K products, delayed to line up with the CORDIC output
  aarm_axis u_axis (
    .clk      (clk),
    .en       (en),
    .in_axis  (ax_in),
    .out_axis (ax_dly),
    .out_kk   (kk_dly)
  );

  // entry assembly; its last register is the output register
  aarm_mat u_mat (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (cord_vld),
    .sin_q    (sin_q),
    .omc_q    (omc_q),
    .ax       (ax_dly),
    .kk       (kk_dly),
    .out_vld  (out_valid),
    .out_word (out_data)
  );

endmodule

// ----- design/aarm_chk.sv -----
module aarm_chk import aarm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // held word must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // pipe frozen (in_ready low) while the output is blocked
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output blocked");

  a_empty_takes_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with empty output");

  // reset flushes the pipe
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind axis_angle_rotation_matrix_unit aarm_chk u_chk (.*);
